### hdl/bgce_pkg.sv
package bgce_pkg;

    // default size of each byte store
    localparam int BUF_BYTES_DEF = 4096;

    typedef enum logic [1:0] {
        OP_WR_SRC = 2'd0,
        OP_WR_DST = 2'd1,
        OP_COPY   = 2'd2,
        OP_RD_DST = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_DONE     = 1'b0,
        ST_OVERFLOW = 1'b1
    } status_t;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

endpackage

### hdl/bit_granular_copy_engine_core.sv
// Bit-granular copy engine: a source and a destination byte store, each BUF_BYTES deep,
// with bit-level copies from one into the other (bit i is bit i%8 of byte i/8, LSB first).
// Input channel in_valid/in_ready carries one command per transfer: write a source byte,
// write a destination byte, read a destination byte, or copy bit_count bits from src_bit
// to dest_bit. Every command gives exactly one result on out_valid/out_ready.
// A copy walks the destination bytes that it touches one byte a cycle: read the byte and the
// next source byte, merge under the edge masks, write back. That single pass through the
// destination store port sets the rate. A zero-length copy or one that runs past either
// buffer returns without walking, the latter with status 1 and nothing written.
// One command is in flight at a time; in_ready is high only while the engine is idle, so
// with out_ready high a new command is taken in the cycle after the previous result loads.
// A finished result sits in the output register until taken; the next command is still
// accepted meanwhile, and its own result waits until the register frees up.
// Reset clears the control state and the output register. Store contents are undefined
// until written; there is no clearing pass.
module bit_granular_copy_engine_core #(
    parameter int BUF_BYTES = bgce_pkg::BUF_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [11:0] byte_address,
    input  logic [7:0]  byte_value,
    input  logic [14:0] dest_bit,
    input  logic [14:0] src_bit,
    input  logic [15:0] bit_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_byte,
    output logic        status
);
    import bgce_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);
    localparam int XW = (AW + 1 > 16) ? AW + 1 : 16;
    localparam int LW = AW + 4;
    localparam int SW = (LW > 17) ? LW : 17;
    localparam logic [SW-1:0] BIT_LIMIT  = SW'(BUF_BYTES * 8);
    localparam logic [XW-1:0] BYTE_LIMIT = XW'(BUF_BYTES);

    typedef enum logic [2:0] {
        IDLE,
        RDWAIT,
        SETUP,
        RUN,
        FINISH
    } state_t;

    function automatic logic [AW-1:0] to_idx(input logic [15:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        return w[AW-1:0];
    endfunction

    state_t         state_reg;
    logic [1:0]     op_reg;
    logic           in_range_reg;
    logic [14:0]    dbit_reg;
    logic [14:0]    sbit_reg;
    logic [15:0]    cnt_reg;

    logic [AW-1:0]  dst_ptr_reg;
    logic [AW-1:0]  src_ptr_reg;
    logic [AW-1:0]  dlast_reg;
    logic [2:0]     sh_reg;
    logic [7:0]     mask_first_reg;
    logic [7:0]     mask_last_reg;
    logic           iss_active_reg;
    logic           iss_first_reg;
    logic           s1_valid_reg;
    logic           s1_first_reg;
    logic           s1_last_reg;
    logic [AW-1:0]  s1_addr_reg;
    logic [7:0]     lo_reg;

    logic           out_valid_reg;
    logic [7:0]     read_byte_reg;
    logic           status_reg;
    logic [7:0]     res_byte_reg;
    logic           res_status_reg;

    logic [7:0]     src_mem [BUF_BYTES];
    logic [7:0]     dst_mem [BUF_BYTES];
    logic [7:0]     src_rdata_reg;
    logic [7:0]     dst_rdata_reg;

    logic           in_accept;
    logic           port_in_range;
    logic [AW-1:0]  port_idx;

    logic [SW-1:0]  src_end;
    logic [SW-1:0]  dst_end;
    logic           overflow;
    logic [16:0]    end_m1;
    logic signed [15:0] s0;
    logic signed [12:0] sa0;
    logic [AW-1:0]  sa0_idx;
    logic [AW-1:0]  d0_idx;
    logic [AW-1:0]  dlast_idx;

    logic           src_we;
    logic           src_re;
    logic [AW-1:0]  src_ra;
    logic           dst_we;
    logic [AW-1:0]  dst_wa;
    logic [7:0]     dst_wd;
    logic           dst_re;
    logic [AW-1:0]  dst_ra;

    logic [15:0]    window;
    logic [15:0]    shifted;
    logic [7:0]     mask;
    logic [7:0]     merged;

    assign in_ready  = (state_reg == IDLE);
    assign in_accept = in_valid && in_ready;
    assign port_in_range = XW'(byte_address) < BYTE_LIMIT;
    assign port_idx  = to_idx(16'(byte_address));

    // copy setup, from the captured command
    assign src_end   = SW'(sbit_reg) + SW'(cnt_reg);
    assign dst_end   = SW'(dbit_reg) + SW'(cnt_reg);
    assign overflow  = (src_end > BIT_LIMIT) || (dst_end > BIT_LIMIT);
    assign end_m1    = 17'(dbit_reg) + 17'(cnt_reg) - 17'd1;
    // source position of bit 0 of the first destination byte, may sit just below zero
    assign s0        = $signed({1'b0, sbit_reg}) - $signed({13'd0, dbit_reg[2:0]});
    assign sa0       = s0[15:3];
    assign sa0_idx   = to_idx(16'(sa0));
    assign d0_idx    = to_idx(16'(dbit_reg[14:3]));
    assign dlast_idx = to_idx(16'(end_m1[16:3]));

    // memory port control
    assign src_we = in_accept && (opcode == OP_WR_SRC) && port_in_range;
    assign src_re = (state_reg == SETUP) || ((state_reg == RUN) && iss_active_reg);
    assign src_ra = (state_reg == SETUP) ? sa0_idx : src_ptr_reg;

    assign dst_re = (in_accept && (opcode == OP_RD_DST))
                    || ((state_reg == RUN) && iss_active_reg);
    assign dst_ra = (state_reg == RUN) ? dst_ptr_reg : port_idx;
    assign dst_we = (in_accept && (opcode == OP_WR_DST) && port_in_range) || s1_valid_reg;
    assign dst_wa = s1_valid_reg ? s1_addr_reg : port_idx;
    assign dst_wd = s1_valid_reg ? merged : byte_value;

    // merge: two neighbouring source bytes aligned onto one destination byte
    assign window  = {src_rdata_reg, lo_reg};
    assign shifted = window >> sh_reg;
    assign mask    = (s1_first_reg ? mask_first_reg : BYTE_ONES)
                     & (s1_last_reg ? mask_last_reg : BYTE_ONES);
    assign merged  = (dst_rdata_reg & ~mask) | (shifted[7:0] & mask);

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[port_idx] <= byte_value;
        end
        if (src_re)
        begin
            src_rdata_reg <= src_mem[src_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dst_we)
        begin
            dst_mem[dst_wa] <= dst_wd;
        end
        if (dst_re)
        begin
            dst_rdata_reg <= dst_mem[dst_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            op_reg         <= OP_WR_SRC;
            in_range_reg   <= 1'b0;
            dbit_reg       <= '0;
            sbit_reg       <= '0;
            cnt_reg        <= '0;
            dst_ptr_reg    <= '0;
            src_ptr_reg    <= '0;
            dlast_reg      <= '0;
            sh_reg         <= '0;
            mask_first_reg <= '0;
            mask_last_reg  <= '0;
            iss_active_reg <= 1'b0;
            iss_first_reg  <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_first_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_addr_reg    <= '0;
            lo_reg         <= '0;
            out_valid_reg  <= 1'b0;
            read_byte_reg  <= '0;
            status_reg     <= ST_DONE;
            res_byte_reg   <= '0;
            res_status_reg <= ST_DONE;
        end
        else
        begin
            // in FINISH the output register is reloaded there instead
            if (out_valid_reg && out_ready && (state_reg != FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg         <= opcode;
                        in_range_reg   <= port_in_range;
                        dbit_reg       <= dest_bit;
                        sbit_reg       <= src_bit;
                        cnt_reg        <= bit_count;
                        res_byte_reg   <= '0;
                        res_status_reg <= ST_DONE;
                        unique case (opcode)
                            OP_WR_SRC, OP_WR_DST: state_reg <= FINISH;
                            OP_RD_DST:            state_reg <= RDWAIT;
                            OP_COPY:              state_reg <= SETUP;
                            default:              state_reg <= FINISH;
                        endcase
                    end
                end
                RDWAIT:
                begin
                    res_byte_reg <= in_range_reg ? dst_rdata_reg : 8'd0;
                    state_reg    <= FINISH;
                end
                SETUP:
                begin
                    priority if (cnt_reg == 16'd0)
                    begin
                        state_reg <= FINISH;
                    end
                    else if (overflow)
                    begin
                        res_status_reg <= ST_OVERFLOW;
                        state_reg      <= FINISH;
                    end
                    else
                    begin
                        dst_ptr_reg    <= d0_idx;
                        src_ptr_reg    <= sa0_idx + AW'(1);
                        dlast_reg      <= dlast_idx;
                        sh_reg         <= s0[2:0];
                        mask_first_reg <= BYTE_ONES << dbit_reg[2:0];
                        mask_last_reg  <= BYTE_ONES >> (3'd7 - end_m1[2:0]);
                        iss_active_reg <= 1'b1;
                        iss_first_reg  <= 1'b1;
                        state_reg      <= RUN;
                    end
                end
                RUN:
                begin
                    // lower half of the merge window trails the read data by one byte
                    lo_reg       <= src_rdata_reg;
                    s1_valid_reg <= iss_active_reg;
                    if (iss_active_reg)
                    begin
                        s1_addr_reg   <= dst_ptr_reg;
                        s1_first_reg  <= iss_first_reg;
                        s1_last_reg   <= (dst_ptr_reg == dlast_reg);
                        iss_first_reg <= 1'b0;
                        dst_ptr_reg   <= dst_ptr_reg + AW'(1);
                        src_ptr_reg   <= src_ptr_reg + AW'(1);
                        if (dst_ptr_reg == dlast_reg)
                        begin
                            iss_active_reg <= 1'b0;
                        end
                    end
                    if (s1_valid_reg && s1_last_reg)
                    begin
                        state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        read_byte_reg <= res_byte_reg;
                        status_reg    <= res_status_reg;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign read_byte = read_byte_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // the last merged byte of a copy ends the copy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RUN) && s1_valid_reg && s1_last_reg |=> (state_reg == FINISH))
        else $error("copy did not finish after its last byte");

    // no copy traffic may remain when a new command can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!s1_valid_reg && !iss_active_reg))
        else $error("copy pipeline busy while idle");

    // a write-back never collides with a write from the command port
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && in_accept))
        else $error("destination write collision");

    // an overflowing copy never reports a data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVERFLOW) |-> (read_byte == 8'd0))
        else $error("data byte on an overflow result");

    // a read result only comes from a read command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && (read_byte != 8'd0) |-> (op_reg == OP_RD_DST))
        else $error("data byte on a non-read result");
`endif

endmodule
